### sv/sstf_pkg.sv
// ---------------------------------------------------------------------------
// sstf_pkg - shared types and constants of the SSTF disk scheduler
// Word layouts of the request and result channels, the request memory word,
// the scan unit control bundle and the sequencer states.
// ---------------------------------------------------------------------------
package sstf_pkg;

	localparam int unsigned MAX_REQUESTS_DEF = 64;
	localparam int unsigned ARR_W   = 24;
	localparam int unsigned CYL_W   = 16;
	localparam int unsigned CLK_W   = 32;
	localparam int unsigned MOVE_W  = 32;
	localparam int unsigned WSUM_W  = 40;
	localparam int unsigned RIDX_W  = 6;
	localparam logic [CYL_W-1:0] START_HEAD_RST = 16'd1;

	// request word
	typedef struct packed {
		logic [ARR_W-1:0] arrival_time;
		logic [CYL_W-1:0] cylinder;
		logic             last_request;
	} req_word_t;

	// result word
	typedef struct packed {
		logic [RIDX_W-1:0] request_index;
		logic [CYL_W-1:0]  served_cylinder;
		logic [CLK_W-1:0]  wait_time;
		logic [MOVE_W-1:0] total_movement;
		logic [WSUM_W-1:0] total_wait;
		logic              last_result;
	} rsp_word_t;

	// one stored request
	typedef struct packed {
		logic [ARR_W-1:0] arrival;
		logic [CYL_W-1:0] cylinder;
	} cand_t;

	// request memory entry: request plus its served flag
	typedef struct packed {
		logic  served;
		cand_t cand;
	} mem_word_t;

	// scan unit control
	typedef struct packed {
		logic clr;
		logic vld;
	} scan_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_BUMP,
		ST_SCAN,
		ST_PICK,
		ST_EMIT
	} state_t;

	// absolute cylinder distance
	function automatic logic [CYL_W-1:0] cyl_dist(input logic [CYL_W-1:0] a,
			input logic [CYL_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

### sv/sstf_ram.sv
// ---------------------------------------------------------------------------
// sstf_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module sstf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/sstf_scan.sv
// ---------------------------------------------------------------------------
// sstf_scan - candidate tracker for one service step
// Takes one memory word per cycle while ctl.vld is set and keeps the nearest arrived unserved
// request and, as a fallback, the earliest unserved request.
// ---------------------------------------------------------------------------
module sstf_scan
	import sstf_pkg::*;
#(
	parameter int unsigned IW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scan_ctl_t        ctl,
	input  mem_word_t        word,
	input  logic [IW-1:0]    idx,
	input  logic [CLK_W-1:0] clock_now,
	input  logic [CYL_W-1:0] head,
	output logic             near_found,
	output logic [IW-1:0]    near_idx,
	output logic [CYL_W-1:0] near_dist,
	output cand_t            near_cand,
	output logic [IW-1:0]    early_idx,
	output cand_t            early_cand
);

	logic             near_found_q;
	logic             early_found_q;
	logic [IW-1:0]    near_idx_q;
	logic [IW-1:0]    early_idx_q;
	logic [CYL_W-1:0] near_dist_q;
	cand_t            near_cand_q;
	cand_t            early_cand_q;
	logic             elig;
	logic [CYL_W-1:0] d;

	assign elig = !word.served && ({8'd0, word.cand.arrival} <= clock_now);
	assign d    = cyl_dist(word.cand.cylinder, head);

	// track flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_found_q  <= 1'b0;
			early_found_q <= 1'b0;
		end else if (ctl.clr) begin
			near_found_q  <= 1'b0;
			early_found_q <= 1'b0;
		end else if (ctl.vld) begin
			if (elig) begin
				near_found_q <= 1'b1;
			end
			if (!word.served) begin
				early_found_q <= 1'b1;
			end
		end
	end

	// keep the best candidates; strict compares let the lowest index win ties
	always_ff @(posedge clk) begin
		if (ctl.vld && !ctl.clr) begin
			if (elig && (!near_found_q || d < near_dist_q)) begin
				near_idx_q  <= idx;
				near_dist_q <= d;
				near_cand_q <= word.cand;
			end
			if (!word.served && (!early_found_q || word.cand.arrival < early_cand_q.arrival)) begin
				early_idx_q  <= idx;
				early_cand_q <= word.cand;
			end
		end
	end

	assign near_found = near_found_q;
	assign near_idx   = near_idx_q;
	assign near_dist  = near_dist_q;
	assign near_cand  = near_cand_q;
	assign early_idx  = early_idx_q;
	assign early_cand = early_cand_q;

endmodule

### sv/sstf_disk_scheduler_unit.sv
// ---------------------------------------------------------------------------
// sstf_disk_scheduler_unit - shortest-seek-time-first disk scheduler
// Requests are loaded while the block is idle. Each service step reads the
// entry at the service count and advances the clock to its arrival if that
// is later, scans all loaded entries through the single read port, picks a
// request and, once the output slot is free, emits the result and writes
// the served flag back. Reset clears the set and the output; start_head
// returns to cylinder 1.
// ---------------------------------------------------------------------------
module sstf_disk_scheduler_unit
	import sstf_pkg::*;
#(
	parameter int unsigned MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_word_t        req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_word_t        rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CYL_W-1:0] cfg_data
);

	localparam int unsigned IW = $clog2(MAX_REQUESTS);
	localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
	localparam int unsigned MW = $bits(mem_word_t);

	state_t state_q, state_d;

	logic [CYL_W-1:0]  start_head_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     svc_q;
	logic [CW-1:0]     iss_q;
	logic [CYL_W-1:0]  head_q;
	logic [CLK_W-1:0]  clock_q;
	logic [MOVE_W-1:0] move_q;
	logic [WSUM_W-1:0] wsum_q;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic [IW-1:0]     sel_idx_q;
	cand_t             sel_cand_q;
	logic [CYL_W-1:0]  sel_dist_q;
	logic [CLK_W-1:0]  sel_clock_q;

	logic              out_vld_q;
	rsp_word_t         out_q;

	// memory port
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	mem_word_t         mem_wword;
	logic [IW-1:0]     mem_raddr;
	logic [MW-1:0]     mem_rdata;
	mem_word_t         mem_rword;

	// scan unit
	scan_ctl_t         scan_ctl;
	logic              near_found;
	logic [IW-1:0]     near_idx;
	logic [CYL_W-1:0]  near_dist;
	cand_t             near_cand;
	logic [IW-1:0]     early_idx;
	cand_t             early_cand;

	// control strobes
	logic              req_acc;
	logic              load_en;
	logic              issue;
	logic              slot_free;
	logic              emit;
	logic              last_svc;
	logic [CW-1:0]     cnt_m1;

	// emit datapath
	logic [CLK_W-1:0]  wait_v;
	logic [IW+5:0]     idx_ext;

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign load_en   = req_acc && (cnt_q != CW'(MAX_REQUESTS));
	assign slot_free = !out_vld_q || !rsp_stall;
	assign cnt_m1    = cnt_q - CW'(1);
	assign last_svc  = (svc_q == cnt_m1);
	assign issue     = ((state_q == ST_BUMP) || (state_q == ST_SCAN)) && (iss_q != cnt_q);
	assign mem_rword = mem_word_t'(mem_rdata);

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		scan_ctl = '{clr: 1'b0, vld: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc && req.last_request) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_BUMP;
			end
			ST_BUMP: begin
				scan_ctl.clr = 1'b1;
				state_d      = ST_SCAN;
			end
			ST_SCAN: begin
				scan_ctl.vld = rd_vld_s1;
				if (rd_vld_s1 && rd_last_s1) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = last_svc ? ST_IDLE : ST_FETCH;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memory port: load writes a fresh entry, emit writes back the served flag
	always_comb begin
		mem_we    = load_en || emit;
		mem_waddr = emit ? sel_idx_q : cnt_q[IW-1:0];
		mem_wword = emit ? mem_word_t'{served: 1'b1, cand: sel_cand_q}
			: mem_word_t'{served: 1'b0,
				cand: cand_t'{arrival: req.arrival_time, cylinder: req.cylinder}};
		mem_raddr = (state_q == ST_FETCH) ? svc_q[IW-1:0] : iss_q[IW-1:0];
	end

	sstf_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_REQUESTS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (MW'(mem_wword)),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sstf_scan #(
		.IW(IW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.word       (mem_rword),
		.idx        (rd_idx_s1),
		.clock_now  (clock_q),
		.head       (head_q),
		.near_found (near_found),
		.near_idx   (near_idx),
		.near_dist  (near_dist),
		.near_cand  (near_cand),
		.early_idx  (early_idx),
		.early_cand (early_cand)
	);

	assign wait_v  = sel_clock_q - {8'd0, sel_cand_q.arrival};
	assign idx_ext = {6'd0, sel_idx_q};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q <= START_HEAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			start_head_q <= cfg_data;
		end
	end

	// set state: counters, head, clock and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			svc_q      <= '0;
			iss_q      <= '0;
			head_q     <= START_HEAD_RST;
			clock_q    <= '0;
			move_q     <= '0;
			wsum_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_last_s1 <= (iss_q == cnt_m1);
				rd_idx_s1  <= iss_q[IW-1:0];
				iss_q      <= iss_q + CW'(1);
			end
			if (load_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (req_acc && req.last_request) begin
				svc_q  <= '0;
				head_q <= start_head_q;
			end
			if (state_q == ST_FETCH) begin
				iss_q <= '0;
			end
			// advance the clock to the arrival of the entry at the service count
			if ((state_q == ST_BUMP) && (clock_q < {8'd0, mem_rword.cand.arrival})) begin
				clock_q <= {8'd0, mem_rword.cand.arrival};
			end
			if (emit) begin
				if (last_svc) begin
					cnt_q   <= '0;
					clock_q <= '0;
					move_q  <= '0;
					wsum_q  <= '0;
				end else begin
					svc_q   <= svc_q + CW'(1);
					head_q  <= sel_cand_q.cylinder;
					clock_q <= sel_clock_q + {16'd0, sel_dist_q};
					move_q  <= move_q + {16'd0, sel_dist_q};
					wsum_q  <= wsum_q + {8'd0, wait_v};
				end
			end
		end
	end

	// pick the nearest arrived request, else jump to the earliest one
	always_ff @(posedge clk) begin
		if (state_q == ST_PICK) begin
			if (near_found) begin
				sel_idx_q   <= near_idx;
				sel_cand_q  <= near_cand;
				sel_dist_q  <= near_dist;
				sel_clock_q <= clock_q;
			end else begin
				sel_idx_q   <= early_idx;
				sel_cand_q  <= early_cand;
				sel_dist_q  <= cyl_dist(early_cand.cylinder, head_q);
				sel_clock_q <= {8'd0, early_cand.arrival};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.request_index   <= idx_ext[5:0];
			out_q.served_cylinder <= sel_cand_q.cylinder;
			out_q.wait_time       <= wait_v;
			out_q.total_movement  <= move_q + {16'd0, sel_dist_q};
			out_q.total_wait      <= wsum_q + {8'd0, wait_v};
			out_q.last_result     <= last_svc;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule

### sv/sstf_chk.sv
// ---------------------------------------------------------------------------
// sstf_chk - port-level checks of the SSTF disk scheduler
// Watches the request and result channels over time; bound to the top level.
// ---------------------------------------------------------------------------
module sstf_chk
	import sstf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_word_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_word_t rsp
);

	// hold a stalled result word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed or dropped");

	// a plain load leaves the block open for the next word
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !req.last_request |=> !req_stall)
		else $error("request channel stalled after a plain load");

	// the final request starts scheduling and closes the request channel
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.last_request |=> req_stall)
		else $error("request channel open while scheduling");

	// results of an unfinished set keep the request channel closed
	a_set_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_result |-> req_stall)
		else $error("request accepted before the set finished");

endmodule

bind sstf_disk_scheduler_unit sstf_chk u_sstf_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
